FILE: rtl/wstq_pkg.sv
// Shared constants, types and codes for the work-stealing task queues.
`timescale 1ns / 1ps
package wstq_pkg;

  localparam int NUM_WORKERS = 8;
  localparam int WORKER_BITS = $clog2(NUM_WORKERS);
  localparam int QUEUE_DEPTH = 64;
  localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
  localparam int POS_BITS    = SLOT_BITS + 1;
  localparam int TASK_BITS   = 32;
  localparam int COUNT_BITS  = 10;
  localparam int STORE_DEPTH = NUM_WORKERS * QUEUE_DEPTH;
  localparam int ADDR_BITS   = WORKER_BITS + SLOT_BITS;

  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_GRAB = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [WORKER_BITS-1:0] worker_t;
  typedef logic [TASK_BITS-1:0]   task_t;

  typedef struct packed {
    logic load;
    logic exec;
  } wstq_cmd_t;

endpackage

FILE: rtl/work_stealing_task_queues.sv
// Top level of the work-stealing task queues: controller, datapath and checks.
`timescale 1ns / 1ps
// Each request is one transaction. The cycle after start is taken (busy high)
// resolves the deque pointers and the round-robin victim pick and performs the
// one access to the single-port task store; the cycle after that carries the
// result on the out_ ports with out_valid high for exactly one cycle, and start
// is already taken again in that cycle, so a new request can be issued as soon
// as busy falls. The receiver cannot stall and must take each result as it
// appears. The task store needs no clearing after reset: entries are only read
// after they were written. Pushes to a full deque (64 tasks) return the full
// status and change nothing; a grab with every deque empty returns the empty
// status.
module work_stealing_task_queues (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic [wstq_pkg::WORKER_BITS-1:0]   in_worker,
  input  logic [wstq_pkg::TASK_BITS-1:0]     in_task_word,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [wstq_pkg::TASK_BITS-1:0]     out_task_out,
  output logic [wstq_pkg::WORKER_BITS-1:0]   out_source_worker,
  output logic                               out_was_stolen,
  output logic [wstq_pkg::COUNT_BITS-1:0]    out_pending_count
);

  wstq_pkg::wstq_cmd_t cmd;

  wstq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  wstq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_worker        (in_worker),
    .in_task_word     (in_task_word),
    .out_status       (out_status),
    .out_task_out     (out_task_out),
    .out_source_worker(out_source_worker),
    .out_was_stolen   (out_was_stolen),
    .out_pending_count(out_pending_count)
  );

  // execute phase is never extended; busy drops again immediately
  assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
    else $error("busy held for more than one cycle");

  // each accepted transaction yields a result strobe after its execute phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing after accepted transaction");

  // nothing to grab means the running total must be zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == wstq_pkg::ST_EMPTY) |-> (out_pending_count == '0))
    else $error("empty reported with tasks still pending");

  // a steal is only flagged on a successful grab
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_stolen) |-> (out_status == wstq_pkg::ST_OK))
    else $error("steal flagged on an unsuccessful request");

endmodule

FILE: rtl/wstq_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module wstq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/wstq_ctrl.sv
// Controller: sequences capture, execute and result strobe for each transaction.
`timescale 1ns / 1ps
module wstq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output wstq_pkg::wstq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic vld_r, vld_nxt;

  always_comb begin
    state_nxt = state_r;
    vld_nxt   = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        vld_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = vld_r;

endmodule

FILE: rtl/wstq_dp.sv
// Datapath: deque pointers, round-robin victim pick, task store and result registers.
`timescale 1ns / 1ps
module wstq_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wstq_pkg::wstq_cmd_t                  cmd,
  input  logic                                 in_func,
  input  logic [wstq_pkg::WORKER_BITS-1:0]     in_worker,
  input  logic [wstq_pkg::TASK_BITS-1:0]       in_task_word,
  output logic [1:0]                           out_status,
  output logic [wstq_pkg::TASK_BITS-1:0]       out_task_out,
  output logic [wstq_pkg::WORKER_BITS-1:0]     out_source_worker,
  output logic                                 out_was_stolen,
  output logic [wstq_pkg::COUNT_BITS-1:0]      out_pending_count
);

  // Request capture
  logic              func_r;
  wstq_pkg::worker_t worker_r;
  wstq_pkg::task_t   task_r;

  // Deque pointers and total
  wstq_pkg::pos_t top_r [wstq_pkg::NUM_WORKERS];
  wstq_pkg::pos_t bot_r [wstq_pkg::NUM_WORKERS];
  wstq_pkg::pos_t top_nxt [wstq_pkg::NUM_WORKERS];
  wstq_pkg::pos_t bot_nxt [wstq_pkg::NUM_WORKERS];
  logic [wstq_pkg::COUNT_BITS-1:0] pend_r, pend_nxt;

  // Result registers
  logic [1:0]        status_r, status_nxt;
  wstq_pkg::worker_t src_r, src_nxt;
  logic              stolen_r, stolen_nxt;
  logic              got_r, got_nxt;

  logic [wstq_pkg::NUM_WORKERS-1:0] nonempty;
  logic [wstq_pkg::NUM_WORKERS-1:0] full;
  logic                             steal_hit;
  wstq_pkg::worker_t                victim;
  wstq_pkg::worker_t                cand;

  logic                             ram_we;
  logic [wstq_pkg::ADDR_BITS-1:0]   ram_addr;
  wstq_pkg::task_t                  ram_rdata;

  // Fill level per deque; positions wrap at twice the depth
  always_comb begin
    for (int i = 0; i < wstq_pkg::NUM_WORKERS; i++) begin
      nonempty[i] = ((bot_r[i] - top_r[i]) != '0);
      full[i]     = (bot_r[i] - top_r[i]) >= wstq_pkg::pos_t'(wstq_pkg::QUEUE_DEPTH);
    end
  end

  // Round-robin victim: nearest non-empty deque after the requester
  always_comb begin
    steal_hit = 1'b0;
    victim    = '0;
    cand      = '0;
    for (int i = wstq_pkg::NUM_WORKERS - 1; i >= 1; i--) begin
      cand = worker_r + wstq_pkg::WORKER_BITS'(i);
      if (nonempty[cand]) begin
        steal_hit = 1'b1;
        victim    = cand;
      end
    end
  end

  always_comb begin
    wstq_pkg::pos_t dec;
    dec = bot_r[worker_r] - wstq_pkg::pos_t'(1);
    for (int i = 0; i < wstq_pkg::NUM_WORKERS; i++) begin
      top_nxt[i] = top_r[i];
      bot_nxt[i] = bot_r[i];
    end
    pend_nxt   = pend_r;
    status_nxt = status_r;
    src_nxt    = src_r;
    stolen_nxt = stolen_r;
    got_nxt    = got_r;
    ram_we     = 1'b0;
    ram_addr   = {worker_r, bot_r[worker_r][wstq_pkg::SLOT_BITS-1:0]};
    if (cmd.exec) begin
      status_nxt = wstq_pkg::ST_EMPTY;
      src_nxt    = '0;
      stolen_nxt = 1'b0;
      got_nxt    = 1'b0;
      if (func_r == wstq_pkg::FN_PUSH) begin
        if (full[worker_r]) begin
          status_nxt = wstq_pkg::ST_FULL;
        end else begin
          ram_we            = 1'b1;
          bot_nxt[worker_r] = bot_r[worker_r] + wstq_pkg::pos_t'(1);
          pend_nxt          = pend_r + wstq_pkg::COUNT_BITS'(1);
          status_nxt        = wstq_pkg::ST_OK;
        end
      end else begin
        if (nonempty[worker_r]) begin
          // pop own bottom
          bot_nxt[worker_r] = dec;
          ram_addr          = {worker_r, dec[wstq_pkg::SLOT_BITS-1:0]};
          status_nxt        = wstq_pkg::ST_OK;
          src_nxt           = worker_r;
          got_nxt           = 1'b1;
        end else if (steal_hit) begin
          // take the oldest task of the victim
          ram_addr        = {victim, top_r[victim][wstq_pkg::SLOT_BITS-1:0]};
          top_nxt[victim] = top_r[victim] + wstq_pkg::pos_t'(1);
          status_nxt      = wstq_pkg::ST_OK;
          src_nxt         = victim;
          stolen_nxt      = 1'b1;
          got_nxt         = 1'b1;
        end
        if ((nonempty[worker_r] || steal_hit) && (pend_r != '0)) begin
          pend_nxt = pend_r - wstq_pkg::COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      worker_r <= in_worker;
      task_r   <= in_task_word;
    end
    status_r <= status_nxt;
    src_r    <= src_nxt;
    stolen_r <= stolen_nxt;
    got_r    <= got_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wstq_pkg::NUM_WORKERS; i++) begin
        top_r[i] <= '0;
        bot_r[i] <= '0;
      end
      pend_r <= '0;
    end else begin
      for (int i = 0; i < wstq_pkg::NUM_WORKERS; i++) begin
        top_r[i] <= top_nxt[i];
        bot_r[i] <= bot_nxt[i];
      end
      pend_r <= pend_nxt;
    end
  end

  wstq_ram #(
    .WIDTH(wstq_pkg::TASK_BITS),
    .DEPTH(wstq_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(task_r),
    .rdata(ram_rdata)
  );

  assign out_status        = status_r;
  assign out_task_out      = got_r ? ram_rdata : '0;
  assign out_source_worker = src_r;
  assign out_was_stolen    = stolen_r;
  assign out_pending_count = pend_r;

endmodule
